/* rtl/core/msm_pkg.sv */
// ----------------------------------------------------------------------------
// msm_pkg - shared types and constants of the multi-voice sample mixer
// Field widths, item codes and the record types that pass between the
// front end, the mixing back end and the result queue.
// ----------------------------------------------------------------------------
package msm_pkg;

  localparam int DEF_VOICES  = 8;
  localparam int DEF_SAMPLES = 4096;

  localparam int OP_W    = 2;
  localparam int VOICE_W = 3;
  localparam int IDX_W   = 12;
  localparam int LEN_W   = 13;
  localparam int SMP_W   = 16;
  localparam int BUS_W   = 20;
  localparam int MASK_W  = 8;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  // result queue depth, also the number of mix items allowed in flight
  localparam int QDEPTH = 4;

  localparam int BUS_MAX = 524287;
  localparam int BUS_MIN = -524288;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_LOAD    = 2'd0;
  localparam op_t OP_TRIGGER = 2'd1;
  localparam op_t OP_MIX     = 2'd2;

  typedef struct packed {
    logic                    valid;
    logic signed [BUS_W-1:0] bus;
    logic [MASK_W-1:0]       mask;
  } mix_desc_t;

  typedef struct packed {
    logic signed [BUS_W-1:0] mixed;
    logic [MASK_W-1:0]       mask;
  } mix_res_t;

endpackage

/* rtl/core/msm_ram.sv */
// ----------------------------------------------------------------------------
// msm_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module msm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/msm_front.sv */
// ----------------------------------------------------------------------------
// msm_front - item decode, voice state and sample banks
// Classifies each accepted item, keeps length, position and play flag of
// every voice, writes bank words and reads the current word of each voice.
// ----------------------------------------------------------------------------
module msm_front #(
  parameter int VOICES            = msm_pkg::DEF_VOICES,
  parameter int SAMPLES_PER_VOICE = msm_pkg::DEF_SAMPLES
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       acc,
  input  msm_pkg::op_t                               op,
  input  logic [msm_pkg::VOICE_W-1:0]                voice,
  input  logic [msm_pkg::IDX_W-1:0]                  sample_index,
  input  logic signed [msm_pkg::SMP_W-1:0]           sample_value,
  input  logic                                       is_end,
  input  logic signed [msm_pkg::BUS_W-1:0]           bus_in,
  output msm_pkg::mix_desc_t                         desc,
  output logic [VOICES-1:0]                          add_en,
  output logic [VOICES-1:0][msm_pkg::SMP_W-1:0]      rd_data
);

  import msm_pkg::*;

  localparam int ADDR_W = $clog2(SAMPLES_PER_VOICE);

  logic [LEN_W-1:0]  len [VOICES];
  logic [IDX_W-1:0]  pos [VOICES];
  logic [VOICES-1:0] playing;

  logic              is_load;
  logic              is_trig;
  logic              is_mix;
  logic              idx_ok;
  logic [VOICES-1:0] hit;
  logic [VOICES-1:0] take;
  logic [VOICES-1:0] ends;
  logic [VOICES-1:0] mask_v;
  logic [MASK_W-1:0] mask8;
  logic [LEN_W-1:0]  pos_inc [VOICES];

  assign is_load = acc && (op == OP_LOAD);
  assign is_trig = acc && (op == OP_TRIGGER);
  assign is_mix  = acc && (op == OP_MIX);
  assign idx_ok  = 32'(sample_index) < SAMPLES_PER_VOICE;

  always_comb begin
    for (int k = 0; k < VOICES; k++) begin
      hit[k]     = 32'(voice) == k;
      take[k]    = playing[k] && ({1'b0, pos[k]} < len[k])
                   && (32'(pos[k]) < SAMPLES_PER_VOICE);
      pos_inc[k] = {1'b0, pos[k]} + LEN_W'(take[k]);
      ends[k]    = pos_inc[k] >= len[k];
      mask_v[k]  = playing[k] && !ends[k];
    end
  end

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < VOICES) begin : g_on
      assign mask8[i] = mask_v[i];
    end else begin : g_off
      assign mask8[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    desc.bus  <= bus_in;
    desc.mask <= mask8;
    if (rst) begin
      playing    <= '0;
      desc.valid <= 1'b0;
      for (int k = 0; k < VOICES; k++) begin
        len[k] <= '0;
        pos[k] <= '0;
      end
    end else begin
      desc.valid <= is_mix;
      for (int k = 0; k < VOICES; k++) begin
        if (is_load && hit[k] && idx_ok && is_end) begin
          len[k] <= {1'b0, sample_index} + LEN_W'(1);
        end
        if (is_trig && hit[k] && (len[k] != '0)) begin
          pos[k]     <= '0;
          playing[k] <= 1'b1;
        end
        // advance, or stop and rewind once the last word has gone out
        if (is_mix && playing[k]) begin
          if (ends[k]) begin
            playing[k] <= 1'b0;
            pos[k]     <= '0;
          end else begin
            pos[k] <= pos_inc[k][IDX_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    add_en <= take;
  end

  for (genvar k = 0; k < VOICES; k++) begin : g_bank
    msm_ram #(
      .WIDTH (SMP_W),
      .DEPTH (SAMPLES_PER_VOICE)
    ) u_bank (
      .clk   (clk),
      .we    (is_load && hit[k] && idx_ok),
      .waddr (ADDR_W'(sample_index)),
      .wdata (sample_value),
      .raddr (ADDR_W'(pos[k])),
      .rdata (rd_data[k])
    );
  end

endmodule

/* rtl/core/msm_back.sv */
// ----------------------------------------------------------------------------
// msm_back - voice summing and saturation
// Adds the words of the voices that play to the bus value in a two-stage
// registered tree and clamps the sum to the bus range.
// ----------------------------------------------------------------------------
module msm_back #(
  parameter int VOICES = msm_pkg::DEF_VOICES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  msm_pkg::mix_desc_t                    desc,
  input  logic [VOICES-1:0]                     add_en,
  input  logic [VOICES-1:0][msm_pkg::SMP_W-1:0] rd_data,
  output logic                                  push,
  output msm_pkg::mix_res_t                     res
);

  import msm_pkg::*;

  localparam int NG     = (VOICES + 3) / 4;
  localparam int PART_W = SMP_W + 2;
  localparam int SUM_W  = BUS_W + $clog2(VOICES) + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(BUS_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(BUS_MIN);

  logic [NG*4-1:0]           en_pad;
  logic signed [SMP_W-1:0]   dat_pad [NG*4];
  logic signed [PART_W-1:0]  part [NG];

  logic                      s2_valid;
  logic signed [BUS_W-1:0]   s2_bus;
  logic [MASK_W-1:0]         s2_mask;
  logic signed [PART_W-1:0]  s2_part [NG];

  logic signed [SUM_W-1:0]   total;

  for (genvar i = 0; i < NG*4; i++) begin : g_pad
    if (i < VOICES) begin : g_on
      assign en_pad[i]  = add_en[i];
      assign dat_pad[i] = rd_data[i];
    end else begin : g_off
      assign en_pad[i]  = 1'b0;
      assign dat_pad[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (en_pad[g*4+j]) begin
          part[g] = part[g] + PART_W'(dat_pad[g*4+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= desc.valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_bus  <= desc.bus;
    s2_mask <= desc.mask;
    for (int g = 0; g < NG; g++) begin
      s2_part[g] <= part[g];
    end
  end

  always_comb begin
    total = SUM_W'(s2_bus);
    for (int g = 0; g < NG; g++) begin
      total = total + SUM_W'(s2_part[g]);
    end
  end

  assign push = s2_valid;

  // clamp to the bus range
  always_comb begin
    res.mask = s2_mask;
    if (total > SAT_HI) begin
      res.mixed = SAT_HI[BUS_W-1:0];
    end else if (total < SAT_LO) begin
      res.mixed = SAT_LO[BUS_W-1:0];
    end else begin
      res.mixed = total[BUS_W-1:0];
    end
  end

endmodule

/* rtl/core/msm_fifo.sv */
// ----------------------------------------------------------------------------
// msm_fifo - result queue
// Short register queue that holds finished results until the receiver
// takes them; the head drives the output channel.
// ----------------------------------------------------------------------------
module msm_fifo #(
  parameter int DEPTH = msm_pkg::QDEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  msm_pkg::mix_res_t din,
  input  logic              pop,
  output logic              valid,
  output msm_pkg::mix_res_t dout
);

  import msm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  mix_res_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    begin
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
    end
  endfunction

  assign valid = count != '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

/* rtl/core/multi_voice_sample_mixer.sv */
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer - polyphonic one-shot sample player
// Loads sample words into per-voice banks, starts voices on trigger and
// mixes every playing voice onto a bus slot with saturation.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one item per handshake. tuser selects load,
// trigger or mix; tlast on a load marks the last word of a sound and sets
// the voice length. Loads and triggers give no result; each mix item gives
// one result item on the output channel (m_axis).
// Throughput: one input item per cycle while tready is high. The bank of
// every voice sits in its own RAM with one read port, so all voices are
// read in the same cycle. A mix item passes the bank read, the partial
// sums, the final sum and the queue, in that order, before it is taken.
// Up to QDEPTH mix items may be in the adder pipeline or the result queue;
// tready drops only while all of them are taken, i.e. when the receiver
// stalls, and returns as soon as it takes a result.
// Reset (synchronous): all voices stopped with length zero, queue empty.
// Bank contents are not cleared; play only words that were loaded.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer #(
  parameter int VOICES            = msm_pkg::DEF_VOICES,
  parameter int SAMPLES_PER_VOICE = msm_pkg::DEF_SAMPLES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // voice [2:0], sample_index [14:3], sample_value [30:15], bus_in [50:31]
  input  logic [msm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // op [1:0]
  input  logic [msm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // mixed_sample [19:0], voices_playing [27:20]
  output logic [msm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  import msm_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic                            acc;
  logic                            pop;
  logic [CNT_W-1:0]                credits;
  op_t                             op;
  mix_desc_t                       desc;
  logic [VOICES-1:0]               add_en;
  logic [VOICES-1:0][SMP_W-1:0]    rd_data;
  logic                            push;
  mix_res_t                        res;
  mix_res_t                        head;

  assign op  = s_axis_tuser;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign pop = m_axis_tvalid && m_axis_tready;

  // count mix items in flight plus results queued
  assign s_axis_tready = credits < CNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CNT_W'(acc && (op == OP_MIX)) - CNT_W'(pop);
    end
  end

  msm_front #(
    .VOICES            (VOICES),
    .SAMPLES_PER_VOICE (SAMPLES_PER_VOICE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .op           (op),
    .voice        (s_axis_tdata[2:0]),
    .sample_index (s_axis_tdata[14:3]),
    .sample_value (s_axis_tdata[30:15]),
    .is_end       (s_axis_tlast),
    .bus_in       (s_axis_tdata[50:31]),
    .desc         (desc),
    .add_en       (add_en),
    .rd_data      (rd_data)
  );

  msm_back #(
    .VOICES (VOICES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .desc    (desc),
    .add_en  (add_en),
    .rd_data (rd_data),
    .push    (push),
    .res     (res)
  );

  msm_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (res),
    .pop   (pop),
    .valid (m_axis_tvalid),
    .dout  (head)
  );

  assign m_axis_tdata = {4'b0000, head.mask, head.mixed};

endmodule

/* rtl/core/msm_checker.sv */
// ----------------------------------------------------------------------------
// msm_checker - port-level checks of the sample mixer
// Watches the two channels of the top level and flags reset, flow-control
// and result-format slips.
// ----------------------------------------------------------------------------
module msm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [msm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("output pending or input closed after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // with no queued result the pipeline alone cannot exhaust the credits
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input closed while no result waits");

  // padding bits of a result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:28] == 4'b0000))
    else $error("result padding not zero");

endmodule

bind multi_voice_sample_mixer msm_checker u_msm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_multi_voice_sample_mixer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer - self-checking bench for the sample mixer
// Drives load, trigger, mix and unused-code items on the input stream, with random
// gaps on both sides. A behavioural model of the voices predicts every mix
// result, and results are compared in order as they leave the output stream.
// A short directed table comes first, then random load/play sequences.
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;
  import msm_pkg::*;

  localparam int NVOICE    = DEF_VOICES;
  localparam int NWORD     = DEF_SAMPLES;
  localparam int RAND_ITEMS = 1700;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    op_t                     op;
    logic [VOICE_W-1:0]      voice;
    logic [IDX_W-1:0]        idx;
    logic signed [SMP_W-1:0] val;
    logic                    last;
    logic signed [BUS_W-1:0] bus;
  } item_t;

  typedef struct packed {
    item_t    it;
    logic     fixed;
    mix_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [IN_TUSER_W-1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // voice model state
  logic signed [SMP_W-1:0] bank_word [NVOICE][NWORD];
  int snd_len  [NVOICE];
  int play_pos [NVOICE];
  bit voice_on [NVOICE];

  // words written so far, and the length of the written run from word zero
  bit loaded [NVOICE][NWORD];
  int filled [NVOICE];

  mix_res_t mix_expect_q [$];
  dir_row_t dir_tab [$];
  int err_cnt = 0;
  int n_sent = 0;
  int stall_cnt = 0;
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;

  multi_voice_sample_mixer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  task automatic mix_predict(input item_t it, output bit has_res, output mix_res_t res);
    int v;
    int sum;
    logic [MASK_W-1:0] m;
    has_res = 1'b0;
    res = '0;
    v = it.voice;
    case (it.op)
      OP_LOAD: begin
        bank_word[v][it.idx] = it.val;
        if (it.last) snd_len[v] = it.idx + 1;
      end
      OP_TRIGGER: begin
        if (snd_len[v] != 0) begin
          play_pos[v] = 0;
          voice_on[v] = 1'b1;
        end
      end
      OP_MIX: begin
        sum = it.bus;
        m = '0;
        for (int k = 0; k < NVOICE; k++) begin
          if (voice_on[k]) begin
            if (play_pos[k] < snd_len[k]) begin
              sum += bank_word[k][play_pos[k]];
              play_pos[k]++;
            end
            // stop at the end, also when the length shrank under the voice
            if (play_pos[k] >= snd_len[k]) begin
              voice_on[k] = 1'b0;
              play_pos[k] = 0;
            end else begin
              m[k] = 1'b1;
            end
          end
        end
        if (sum > BUS_MAX) sum = BUS_MAX;
        if (sum < BUS_MIN) sum = BUS_MIN;
        res.mixed = sum[BUS_W-1:0];
        res.mask = m;
        has_res = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input item_t it, input bit fixed, input mix_res_t fixed_res);
    int v;
    int gap;
    bit has_res;
    mix_res_t res;
    v = it.voice;
    if (it.op == OP_LOAD) begin
      // never let a length reach past the written words
      if (it.last && it.idx > filled[v]) it.last = 1'b0;
      loaded[v][it.idx] = 1'b1;
      while (filled[v] < NWORD && loaded[v][filled[v]]) filled[v]++;
    end
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, it.bus, it.val, it.idx, it.voice};
    s_tuser  <= it.op;
    s_tlast  <= it.last;
    do @(posedge clk); while (!s_axis_tready);
    mix_predict(it, has_res, res);
    if (has_res) mix_expect_q.push_back(fixed ? fixed_res : res);
    if (it.op != 2'd3) n_sent++;
  endtask

  task automatic put(input int op, input int v, input int idx, input int val,
                     input int last, input int bus);
    item_t it;
    it.op    = op[OP_W-1:0];
    it.voice = v[VOICE_W-1:0];
    it.idx   = idx[IDX_W-1:0];
    it.val   = val[SMP_W-1:0];
    it.last  = last[0];
    it.bus   = bus[BUS_W-1:0];
    send_item(it, 1'b0, '0);
  endtask

  function automatic dir_row_t row(input int op, input int v, input int idx, input int val,
                                   input int last, input int bus, input bit fixed,
                                   input int exp_mixed, input int exp_mask);
    dir_row_t r;
    r.it.op    = op[OP_W-1:0];
    r.it.voice = v[VOICE_W-1:0];
    r.it.idx   = idx[IDX_W-1:0];
    r.it.val   = val[SMP_W-1:0];
    r.it.last  = last[0];
    r.it.bus   = bus[BUS_W-1:0];
    r.fixed     = fixed;
    r.res.mixed = exp_mixed[BUS_W-1:0];
    r.res.mask  = exp_mask[MASK_W-1:0];
    return r;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(0, 511) - 256;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_bus();
    case ($urandom_range(0, 7))
      0: return BUS_MAX;
      1: return BUS_MIN;
      2, 3: return $urandom_range(0, 8191) - 4096;
      default: return $urandom_range(0, 1048575) - 524288;
    endcase
  endfunction

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin src_idle = 1'b0; snk_idle = 1'b0; end
      1: begin src_idle = 1'b1; snk_idle = 1'b0; end
      2: begin src_idle = 1'b0; snk_idle = 1'b1; end
      default: begin src_idle = 1'b1; snk_idle = 1'b1; end
    endcase
  endtask

  // result side: random back-pressure, in-order compare
  initial begin
    int gap;
    mix_res_t act;
    mix_res_t exp_res;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = snk_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      act.mixed = m_axis_tdata[BUS_W-1:0];
      act.mask  = m_axis_tdata[BUS_W+MASK_W-1:BUS_W];
      if (mix_expect_q.size() == 0) begin
        $display("%0t unexpected result: mixed_sample %0d voices_playing %02h",
                 $time, $signed(act.mixed), act.mask);
        err_cnt++;
      end else begin
        exp_res = mix_expect_q.pop_front();
        if (act.mixed !== exp_res.mixed) begin
          $display("%0t mixed_sample mismatch: expected %0d actual %0d",
                   $time, $signed(exp_res.mixed), $signed(act.mixed));
          err_cnt++;
        end
        if (act.mask !== exp_res.mask) begin
          $display("%0t voices_playing mismatch: expected %02h actual %02h",
                   $time, exp_res.mask, act.mask);
          err_cnt++;
        end
      end
    end
  end

  // end the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int v;
    int len;
    int nm;
    for (int k = 0; k < NVOICE; k++) begin
      snd_len[k] = 0;
      play_pos[k] = 0;
      voice_on[k] = 1'b0;
      filled[k] = 0;
      for (int j = 0; j < NWORD; j++) begin
        bank_word[k][j] = '0;
        loaded[k][j] = 1'b0;
      end
    end

    // idle voices pass the bus through; then saturation both ways,
    // retrigger, a length cut under a playing voice, ignored items
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, BUS_MAX, 1, BUS_MAX, 0));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, BUS_MIN, 1, BUS_MIN, 0));
    dir_tab.push_back(row(OP_TRIGGER, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(row(OP_LOAD, 0, 0, 32767, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_LOAD, 0, 1, -32768, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_LOAD, 1, 0, 32767, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_LOAD, 7, 0, -1, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_LOAD, 2, 4095, 23130, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(3, 7, 4095, -1, 1, -1, 0, 0, 0));
    dir_tab.push_back(row(OP_TRIGGER, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_TRIGGER, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_TRIGGER, 7, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, BUS_MAX, 1, BUS_MAX, 1));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, BUS_MIN, 1, BUS_MIN, 0));
    dir_tab.push_back(row(OP_TRIGGER, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_TRIGGER, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_LOAD, 0, 0, 100, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_TRIGGER, 2, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MIX, 0, 0, 0, 0, 12345, 0, 0, 0));
    dir_tab.push_back(row(OP_LOAD, 0, 1, -32768, 1, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].fixed, dir_tab[i].res);

    while (n_sent < RAND_ITEMS) begin
      pick_idling();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // load a whole sound, mostly short
          v = $urandom_range(0, NVOICE - 1);
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
          for (int i = 0; i < len; i++) put(OP_LOAD, v, i, pick_sample(), i == len - 1, 0);
        end
        4, 5, 6, 7: begin
          repeat ($urandom_range(1, 4)) put(OP_TRIGGER, $urandom_range(0, NVOICE - 1), 0, 0, 0, 0);
          nm = $urandom_range(4, 30);
          for (int i = 0; i < nm; i++) begin
            if ($urandom_range(0, 9) == 0)
              put(OP_TRIGGER, $urandom_range(0, NVOICE - 1), 0, 0, 0, 0);
            put(OP_MIX, 0, 0, 0, 0, pick_bus());
          end
        end
        8: begin
          // cut a sound short, possibly while it plays
          v = $urandom_range(0, NVOICE - 1);
          len = (filled[v] > 0) ? $urandom_range(0, filled[v] - 1) : 0;
          put(OP_LOAD, v, len, pick_sample(), 1, 0);
          repeat ($urandom_range(1, 6)) put(OP_MIX, 0, 0, 0, 0, pick_bus());
        end
        default: begin
          repeat ($urandom_range(4, 12))
            put($urandom_range(0, 3), $urandom_range(0, NVOICE - 1), $urandom_range(0, NWORD - 1),
                pick_sample(), $urandom_range(0, 1), pick_bus());
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (mix_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
